/* src/crft_pkg.sv */
// Shared types and operation codes for the request queue with throttle.
package crft_pkg;

	// Operation codes carried on the mode field.
	localparam logic [2:0] MODE_ENQUEUE  = 3'd0;
	localparam logic [2:0] MODE_CANCEL   = 3'd1;
	localparam logic [2:0] MODE_DISPATCH = 3'd2;
	localparam logic [2:0] MODE_TAKE     = 3'd3;
	localparam logic [2:0] MODE_FREE     = 3'd4;
	localparam logic [2:0] MODE_CLEAR    = 3'd5;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EXEC   = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_SHIFT  = 5'b01000,
		ST_RESULT = 5'b10000
	} crft_state_t;

	// Request from the sequencer to the active-slot counter.
	typedef struct packed {
		logic take;
		logic free;
	} thr_req_t;

	// Status returned by the active-slot counter.
	typedef struct packed {
		logic refused;
		logic throttled;
	} thr_stat_t;

endpackage

/* src/crft_store.sv */
// Queue storage: one write port and one read port with registered read data.
module crft_store #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 16,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* src/crft_throttle.sv */
// Active-slot counter with the configurable concurrency limit.
module crft_throttle
	import crft_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  thr_req_t   req,
	output thr_stat_t  stat
);

	logic [7:0] max_active_q;
	logic [7:0] active_q;
	logic       take_bad;
	logic       free_bad;

	// A slot may only be taken below the limit and only freed above zero.
	assign take_bad = req.take && (active_q >= max_active_q);
	assign free_bad = req.free && (active_q == 8'd0);

	assign stat.refused   = take_bad || free_bad;
	assign stat.throttled = (active_q == max_active_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_active_q <= 8'd8;
			active_q     <= 8'd0;
		end else begin
			if (cfg_we) begin
				max_active_q <= cfg_wdata;
			end
			if (req.take && !take_bad) begin
				active_q <= active_q + 8'd1;
			end else if (req.free && !free_bad) begin
				active_q <= active_q - 8'd1;
			end
		end
	end

endmodule

/* src/cancelable_request_fifo_throttle.sv */
// Top level of the request queue with cancel and concurrency limit.
// One transaction is worked on at a time and in_stall stays high until its result has been
// loaded into the output register. Enqueue, slot taken, slot freed, clear and unused modes
// go from the execute state straight to the result state. Cancel and dispatch walk the queue
// through the single read port of the storage: they examine entries up to the match, then
// move each later entry one place towards the head; a cancel that misses ends after the last
// entry, and on an empty queue both go straight to the result state. The result register may
// hold a finished result while the next transaction is accepted; a second result waits until
// out_stall drops.
module cancelable_request_fifo_throttle
	import crft_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [15:0] request_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic        dispatch_valid,
	output logic [15:0] dispatch_id,
	output logic        throttled,
	output logic [4:0]  queued_count,
	output logic        error
);

	localparam int KEEP_W = (ID_BITS < 16) ? ID_BITS : 16;
	localparam int IDX_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int PTR_W  = $clog2(QUEUE_DEPTH + 2);
	localparam int QC_W   = (CNT_W > 5) ? CNT_W : 5;

	crft_state_t       state_q;
	logic [2:0]        mode_q;
	logic [KEEP_W-1:0] id_q;
	logic [CNT_W-1:0]  count_q;
	logic [PTR_W-1:0]  rd_idx_q;
	logic [PTR_W-1:0]  chk_idx_q;
	logic [PTR_W-1:0]  wr_idx_q;
	logic              chk_q;
	logic              res_found_q;
	logic              res_dvalid_q;
	logic [KEEP_W-1:0] res_did_q;
	logic              res_err_q;

	logic              out_valid_q;
	logic              out_found_q;
	logic              out_dvalid_q;
	logic [KEEP_W-1:0] out_did_q;
	logic              out_throttled_q;
	logic [CNT_W-1:0]  out_count_q;
	logic              out_err_q;

	logic              mem_wr_en;
	logic [IDX_W-1:0]  mem_wr_addr;
	logic [KEEP_W-1:0] mem_wr_data;
	logic              mem_rd_en;
	logic [KEEP_W-1:0] mem_rd_data;

	logic [PTR_W-1:0]  count_p;
	logic              is_dispatch;
	logic              hit;
	logic              shift_more;
	logic              res_load;
	thr_req_t          thr_req;
	thr_stat_t         thr_stat;
	logic [QC_W-1:0]   qc_ext;

	assign count_p     = PTR_W'(count_q);
	assign is_dispatch = (mode_q == MODE_DISPATCH);
	// Dispatch is a cancel whose first examined entry always matches.
	assign hit         = chk_q && (is_dispatch || (mem_rd_data == id_q));
	assign shift_more  = (wr_idx_q + PTR_W'(1)) < count_p;
	assign res_load    = (state_q == ST_RESULT) && (!out_valid_q || !out_stall);

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		thr_req.take = 1'b0;
		thr_req.free = 1'b0;
		if (state_q == ST_EXEC) begin
			thr_req.take = (mode_q == MODE_TAKE);
			thr_req.free = (mode_q == MODE_FREE);
		end
	end

	crft_throttle u_throttle (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (thr_req),
		.stat      (thr_stat)
	);

	// Memory ports: enqueue writes at the tail, compaction writes behind the read pointer.
	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = count_q[IDX_W-1:0];
		mem_wr_data = id_q;
		if (state_q == ST_EXEC && mode_q == MODE_ENQUEUE
				&& count_q < CNT_W'(QUEUE_DEPTH)) begin
			mem_wr_en = 1'b1;
		end else if (state_q == ST_SHIFT && shift_more) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = wr_idx_q[IDX_W-1:0];
			mem_wr_data = mem_rd_data;
		end
	end

	assign mem_rd_en = ((state_q == ST_SCAN) || (state_q == ST_SHIFT))
		&& (rd_idx_q < PTR_W'(QUEUE_DEPTH));

	crft_store #(
		.DEPTH  (QUEUE_DEPTH),
		.WIDTH  (KEEP_W),
		.ADDR_W (IDX_W)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (rd_idx_q[IDX_W-1:0]),
		.rd_data (mem_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			chk_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (mode_q) inside
						MODE_ENQUEUE: begin
							state_q <= ST_RESULT;
							if (count_q < CNT_W'(QUEUE_DEPTH)) begin
								count_q <= count_q + CNT_W'(1);
							end
						end
						MODE_CANCEL, MODE_DISPATCH: begin
							if (count_q != '0) begin
								state_q <= ST_SCAN;
							end else begin
								state_q <= ST_RESULT;
							end
						end
						MODE_CLEAR: begin
							state_q <= ST_RESULT;
							count_q <= '0;
						end
						default: begin
							state_q <= ST_RESULT;
						end
					endcase
					chk_q <= 1'b0;
				end
				ST_SCAN: begin
					chk_q <= (rd_idx_q < count_p);
					if (hit) begin
						state_q <= ST_SHIFT;
					end else if (chk_q && (chk_idx_q + PTR_W'(1) == count_p)) begin
						state_q <= ST_RESULT;
					end
				end
				ST_SHIFT: begin
					if (!shift_more) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Per-transaction working registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			mode_q <= mode;
			id_q   <= request_id[KEEP_W-1:0];
		end
		case (state_q)
			ST_EXEC: begin
				rd_idx_q     <= '0;
				res_found_q  <= 1'b0;
				res_dvalid_q <= 1'b0;
				res_did_q    <= '0;
				case (mode_q) inside
					MODE_ENQUEUE: begin
						res_err_q <= (count_q >= CNT_W'(QUEUE_DEPTH));
					end
					MODE_TAKE, MODE_FREE: begin
						res_err_q <= thr_stat.refused;
					end
					MODE_CANCEL, MODE_DISPATCH, MODE_CLEAR: begin
						res_err_q <= 1'b0;
					end
					default: begin
						res_err_q <= 1'b1;
					end
				endcase
			end
			ST_SCAN: begin
				rd_idx_q  <= rd_idx_q + PTR_W'(1);
				chk_idx_q <= rd_idx_q;
				if (hit) begin
					wr_idx_q <= chk_idx_q;
					if (is_dispatch) begin
						res_dvalid_q <= 1'b1;
						res_did_q    <= mem_rd_data;
					end else begin
						res_found_q <= 1'b1;
					end
				end
			end
			ST_SHIFT: begin
				rd_idx_q <= rd_idx_q + PTR_W'(1);
				wr_idx_q <= wr_idx_q + PTR_W'(1);
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_found_q     <= res_found_q;
			out_dvalid_q    <= res_dvalid_q;
			out_did_q       <= res_did_q;
			out_throttled_q <= thr_stat.throttled;
			out_count_q     <= count_q;
			out_err_q       <= res_err_q;
		end
	end

	assign qc_ext = QC_W'(out_count_q);

	assign out_valid      = out_valid_q;
	assign found          = out_found_q;
	assign dispatch_valid = out_dvalid_q;
	assign dispatch_id    = 16'(out_did_q);
	assign throttled      = out_throttled_q;
	assign queued_count   = qc_ext[4:0];
	assign error          = out_err_q;

endmodule

/* dv/cancelable_request_fifo_throttle_tb.sv */
// Self-checking testbench for the request queue with cancel and concurrency limit.
module cancelable_request_fifo_throttle_tb
	import crft_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUEUE_DEPTH = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 50;

	// Mode values that the block must refuse.
	localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
	localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

	typedef struct packed {
		logic        found;
		logic        dispatch_valid;
		logic [15:0] dispatch_id;
		logic        throttled;
		logic [4:0]  queued_count;
		logic        error;
	} queue_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = 8'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  mode = MODE_ENQUEUE;
	logic [15:0] request_id = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        found;
	logic        dispatch_valid;
	logic [15:0] dispatch_id;
	logic        throttled;
	logic [4:0]  queued_count;
	logic        error;

	// Shadow state of the block, advanced as each transaction is accepted.
	logic [15:0]   waiting_ids[$];
	logic [7:0]    active_slots = 8'd0;
	logic [7:0]    slot_limit = 8'd8;
	queue_result_t expected_results[$];

	int           mismatch_count = 0;
	int           cycle_count = 0;
	int           burst_left = 0;
	stall_style_t stall_style = STALL_NONE;

	cancelable_request_fifo_throttle uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.request_id     (request_id),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.found          (found),
		.dispatch_valid (dispatch_valid),
		.dispatch_id    (dispatch_id),
		.throttled      (throttled),
		.queued_count   (queued_count),
		.error          (error)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// The receiver switches between four stall habits, chosen at random.
	always @(posedge clk) begin
		if (cycle_count % 256 == 0)
			stall_style <= stall_style_t'($urandom_range(0, 3));
		case (stall_style)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= (cycle_count % 9) < 4;
		endcase
	end

	function automatic queue_result_t apply_request_op(input logic [2:0] op,
			input logic [15:0] id);
		queue_result_t r;
		int hit;
		r = '0;
		hit = -1;
		case (op)
			MODE_ENQUEUE: begin
				if (waiting_ids.size() >= QUEUE_DEPTH)
					r.error = 1'b1;
				else
					waiting_ids.insert(waiting_ids.size(), id);
			end
			MODE_CANCEL: begin
				// Only the entry nearest the head is removed.
				foreach (waiting_ids[i])
					if (hit < 0 && waiting_ids[i] == id)
						hit = i;
				if (hit >= 0) begin
					waiting_ids.delete(hit);
					r.found = 1'b1;
				end
			end
			MODE_DISPATCH: begin
				if (waiting_ids.size() > 0) begin
					r.dispatch_valid = 1'b1;
					r.dispatch_id = waiting_ids[0];
					waiting_ids.delete(0);
				end
			end
			MODE_TAKE: begin
				if (active_slots >= slot_limit)
					r.error = 1'b1;
				else
					active_slots = active_slots + 8'd1;
			end
			MODE_FREE: begin
				if (active_slots == 8'd0)
					r.error = 1'b1;
				else
					active_slots = active_slots - 8'd1;
			end
			MODE_CLEAR: waiting_ids.delete();
			default: r.error = 1'b1;
		endcase
		r.throttled = (active_slots == slot_limit);
		r.queued_count = 5'(waiting_ids.size());
		return r;
	endfunction

	function automatic logic [15:0] pick_id();
		// A small pool makes duplicates and cancel hits common.
		if ($urandom_range(0, 1) == 0)
			return 16'($urandom_range(0, 7));
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		queue_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: result expected none actual dispatch_id=%0h count=%0d",
					$time, dispatch_id, queued_count);
			end else begin
				want = expected_results[0];
				expected_results.delete(0);
				check_field("found", 16'(want.found), 16'(found));
				check_field("dispatch_valid", 16'(want.dispatch_valid), 16'(dispatch_valid));
				check_field("dispatch_id", want.dispatch_id, dispatch_id);
				check_field("throttled", 16'(want.throttled), 16'(throttled));
				check_field("queued_count", 16'(want.queued_count), 16'(queued_count));
				check_field("error", 16'(want.error), 16'(error));
			end
		end
	end

	// Presents one transaction and holds it until accepted; may then leave a gap.
	task automatic issue_op(input logic [2:0] op, input logic [15:0] id);
		in_valid <= 1'b1;
		mode <= op;
		request_id <= id;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_results.insert(expected_results.size(), apply_request_op(op, id));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(posedge clk);
			if ($urandom_range(0, 3) == 0)
				burst_left = $urandom_range(30, 80);
			else
				burst_left = $urandom_range(0, 12);
		end
	endtask

	task automatic drain_results();
		if (in_valid)
			in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		slot_limit = value;
	endtask

	task automatic test_queue_order();
		issue_op(MODE_ENQUEUE, 16'h0000);
		issue_op(MODE_ENQUEUE, 16'hFFFF);
		issue_op(MODE_ENQUEUE, 16'hFFFF);
		issue_op(MODE_ENQUEUE, 16'h1234);
		issue_op(MODE_CANCEL, 16'hFFFF);
		issue_op(MODE_CANCEL, 16'hBEEF);
		issue_op(MODE_DISPATCH, 16'h0000);
		issue_op(MODE_DISPATCH, 16'h0000);
		issue_op(MODE_DISPATCH, 16'h0000);
		issue_op(MODE_DISPATCH, 16'hFFFF);
	endtask

	task automatic test_clear_and_unused();
		issue_op(MODE_ENQUEUE, 16'hA5A5);
		issue_op(MODE_ENQUEUE, 16'h5A5A);
		issue_op(MODE_CLEAR, 16'h0000);
		issue_op(MODE_UNUSED_6, 16'hFFFF);
		issue_op(MODE_UNUSED_7, 16'h0000);
	endtask

	task automatic test_slot_limits();
		write_limit(8'd1);
		issue_op(MODE_TAKE, 16'h0000);
		issue_op(MODE_TAKE, 16'h0000);
		issue_op(MODE_FREE, 16'h0000);
		issue_op(MODE_FREE, 16'h0000);
		// With a zero limit an idle counter already reads as throttled.
		write_limit(8'd0);
		issue_op(MODE_TAKE, 16'h0000);
		write_limit(8'd255);
		issue_op(MODE_TAKE, 16'h0000);
		issue_op(MODE_TAKE, 16'h0000);
		issue_op(MODE_TAKE, 16'h0000);
		// Limit now below the active count: taking is refused, freeing still works.
		write_limit(8'd1);
		issue_op(MODE_TAKE, 16'h0000);
		issue_op(MODE_FREE, 16'h0000);
		issue_op(MODE_FREE, 16'h0000);
	endtask

	task automatic test_random_traffic(input logic [7:0] limit, input int n_ops);
		int sent;
		int k;
		logic [15:0] id;
		write_limit(limit);
		sent = 0;
		// Climb to the limit and one beyond, then free some or all slots.
		while (active_slots < slot_limit) begin
			issue_op(MODE_TAKE, 16'($urandom));
			sent++;
		end
		issue_op(MODE_TAKE, 16'($urandom));
		k = (active_slots <= 10) ? active_slots + 1 : $urandom_range(1, 10);
		repeat (k)
			issue_op(MODE_FREE, 16'($urandom));
		sent += k + 1;
		while (sent < n_ops) begin
			case ($urandom_range(0, 9)) inside
				0, 1, 2: begin
					k = $urandom_range(1, 18);
					repeat (k)
						issue_op(MODE_ENQUEUE, pick_id());
				end
				3, 4: begin
					k = $urandom_range(1, 4);
					repeat (k) begin
						if (waiting_ids.size() > 0 && $urandom_range(0, 3) != 0)
							id = waiting_ids[$urandom_range(0, waiting_ids.size() - 1)];
						else
							id = pick_id();
						issue_op(MODE_CANCEL, id);
					end
				end
				5: begin
					k = $urandom_range(1, 6);
					repeat (k)
						issue_op(MODE_DISPATCH, 16'($urandom));
				end
				6: begin
					k = $urandom_range(1, 6);
					repeat (k)
						issue_op($urandom_range(0, 1) ? MODE_TAKE : MODE_FREE, 16'($urandom));
				end
				7: begin
					k = $urandom_range(1, 5);
					repeat (k)
						issue_op(3'($urandom_range(0, 7)), 16'($urandom));
				end
				8: begin
					k = 1;
					issue_op(MODE_CLEAR, 16'($urandom));
				end
				default: begin
					// Let every outstanding transaction finish before the next one.
					k = 1;
					drain_results();
					issue_op(MODE_DISPATCH, 16'($urandom));
				end
			endcase
			sent += k;
		end
	endtask

	initial begin
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);
		test_queue_order();
		test_clear_and_unused();
		test_slot_limits();
		test_random_traffic(8'd8, 280);
		test_random_traffic(8'd1, 280);
		test_random_traffic(8'd255, 300);
		test_random_traffic(8'd0, 280);
		test_random_traffic(8'($urandom_range(2, 254)), 280);
		test_random_traffic(8'd16, 280);
		drain_results();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
